// ===== src/sst_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, codes and defaults of the sorted symbol table.
// Depends on nothing; the interfaces, the core and the engine import it.
package sst_pkg;

   localparam int DEF_CAPACITY  = 256;
   localparam int DEF_KEY_WIDTH = 32;

   localparam int KEY_FIELD_W = 32;
   localparam int INDEX_W     = 8;
   localparam int ID_W        = 8;
   localparam int COUNT_W     = 9;

   typedef enum logic [1:0] {
      MODE_ADD       = 2'd0,
      MODE_LOOKUP    = 2'd1,
      MODE_READ_ID   = 2'd2,
      MODE_READ_RANK = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_NOT_FOUND = 2'd1,
      STATUS_FULL      = 2'd2,
      STATUS_RANGE     = 2'd3
   } status_type;

   typedef struct packed {
      status_type                      status;
      logic [ID_W-1:0]                 id;
      logic signed [KEY_FIELD_W-1:0]   key_out;
      logic [COUNT_W-1:0]              unique_count;
      logic [COUNT_W-1:0]              total_count;
   } result_type;

endpackage

// ===== src/sst_if.sv =====
`timescale 1ns / 1ps
// Request and response channel interfaces of the sorted symbol table.
// Depends on sst_pkg for the field types and widths.
interface sst_req_if import sst_pkg::*; ();
   logic                          valid;
   logic                          ready;
   mode_type                      mode;
   logic signed [KEY_FIELD_W-1:0] key;
   logic [INDEX_W-1:0]            index;

   modport source (output valid, mode, key, index, input ready);
   modport sink   (input valid, mode, key, index, output ready);
endinterface

interface sst_rsp_if import sst_pkg::*; ();
   logic                          valid;
   logic                          ready;
   status_type                    status;
   logic [ID_W-1:0]               id;
   logic signed [KEY_FIELD_W-1:0] key_out;
   logic [COUNT_W-1:0]            unique_count;
   logic [COUNT_W-1:0]            total_count;

   modport source (output valid, status, id, key_out, unique_count, total_count,
                   input ready);
   modport sink   (input valid, status, id, key_out, unique_count, total_count,
                   output ready);
endinterface

// ===== src/sorted_symbol_table_core.sv =====
`timescale 1ns / 1ps
// Top level of the sorted symbol table: sequencer plus response register.
// Depends on sst_pkg, sst_if, sst_ram and sst_engine.
//
// Usage. Requests arrive on req_chan (mode, key, index); each one gives
// exactly one transfer on rsp_chan carrying status, id, key_out and the
// distinct and total key counts as they stand after the request.
// Mode 0 adds a key, mode 1 looks a key up, mode 2 reads a key by its id and
// mode 3 reads the key and latest id at a given rank among the distinct keys.
//
// Reads by id or rank do a single memory read; a full table or an index
// out of range answers without one. A lookup runs a binary search over the
// sorted memory, one read and one compare per halving step. An add does the
// same search and, for a new key, then moves every larger entry up one place
// at one entry per cycle through the sorted memory's single read and write
// ports.
//
// One request is in flight at a time; req_chan.ready is high while the
// sequencer is idle. A finished result moves into the response register, so
// a stalled receiver holds back the next result but not the next request.
// Reset is synchronous and empties the table at once: the counts clear and
// no memory clearing pass is needed, as every read is checked against them.
module sorted_symbol_table_core import sst_pkg::*; #(
   parameter int CAPACITY  = DEF_CAPACITY,
   parameter int KEY_WIDTH = DEF_KEY_WIDTH
) (
   input  logic      clock,
   input  logic      reset,
   sst_req_if.sink   req_chan,
   sst_rsp_if.source rsp_chan
);

   logic       res_valid;
   logic       res_ready;
   result_type res;
   logic       rsp_valid_ff;
   result_type rsp_data_ff;

   sst_engine #(.CAPACITY(CAPACITY), .KEY_WIDTH(KEY_WIDTH)) u_engine (
      .clock     (clock),
      .reset     (reset),
      .req       (req_chan),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res       (res)
   );

   // The response register takes a new result when it is empty or when its
   // current contents leave in the same cycle.
   assign res_ready = !rsp_valid_ff || rsp_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_ready) begin
         rsp_valid_ff <= res_valid;
      end
      if (res_valid && res_ready) begin
         rsp_data_ff <= res;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.status       = rsp_data_ff.status;
   assign rsp_chan.id           = rsp_data_ff.id;
   assign rsp_chan.key_out      = rsp_data_ff.key_out;
   assign rsp_chan.unique_count = rsp_data_ff.unique_count;
   assign rsp_chan.total_count  = rsp_data_ff.total_count;

   // Once a request is taken the sequencer is no longer idle in the following cycle.
   assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> !req_chan.ready)
      else $error("request taken while the previous one was still starting");

   // Every error answer carries a zero id and a zero key.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.status != STATUS_OK) |->
         (rsp_chan.id == '0 && rsp_chan.key_out == '0))
      else $error("error response with a non-zero id or key");

   // A full-table answer only comes once every place has been used.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.status == STATUS_FULL) |->
         (rsp_chan.total_count == COUNT_W'(CAPACITY)))
      else $error("table reported full below capacity");

endmodule

// ===== src/sst_ram.sv =====
`timescale 1ns / 1ps
// Simple dual-port synchronous memory, one write and one registered read port.
// Depends on nothing.
module sst_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== src/sst_engine.sv =====
`timescale 1ns / 1ps
// Sequencer of the sorted symbol table: binary search, sorted insertion
// and reads over the two table memories. Depends on sst_pkg, sst_if, sst_ram.
module sst_engine import sst_pkg::*; #(
   parameter int CAPACITY  = DEF_CAPACITY,
   parameter int KEY_WIDTH = DEF_KEY_WIDTH
) (
   input  logic          clock,
   input  logic          reset,
   sst_req_if.sink       req,
   output logic          res_valid,
   input  logic          res_ready,
   output result_type    res
);

   localparam int AW   = $clog2(CAPACITY);
   localparam int CW   = $clog2(CAPACITY + 1);
   localparam int KW   = KEY_WIDTH;
   localparam int CMPW = (CW > INDEX_W) ? CW : INDEX_W;
   localparam int SW   = KW + AW;

   typedef enum logic [7:0] {
      S_IDLE    = 8'b0000_0001,
      S_SEARCH  = 8'b0000_0010,
      S_COMPARE = 8'b0000_0100,
      S_PROBE   = 8'b0000_1000,
      S_SHIFT   = 8'b0001_0000,
      S_INSERT  = 8'b0010_0000,
      S_READ    = 8'b0100_0000,
      S_DONE    = 8'b1000_0000
   } state_type;

   state_type       state_ff, state_in;
   mode_type        mode_ff, mode_in;
   logic [KW-1:0]   key_ff, key_in;
   logic [CW-1:0]   lo_ff, lo_in;
   logic [CW-1:0]   hi_ff, hi_in;
   logic [AW-1:0]   sp_ff, sp_in;
   logic [AW-1:0]   nid_ff, nid_in;
   logic [CW-1:0]   added_ff, added_in;
   logic [CW-1:0]   distinct_ff, distinct_in;
   status_type      res_status_ff, res_status_in;
   logic [ID_W-1:0] res_id_ff, res_id_in;
   logic [KW-1:0]   res_kout_ff, res_kout_in;

   logic            id_we;
   logic [AW-1:0]   id_waddr, id_raddr;
   logic [KW-1:0]   id_wdata, id_rdata;
   logic            srt_we;
   logic [AW-1:0]   srt_waddr, srt_raddr;
   logic [SW-1:0]   srt_wdata, srt_rdata;
   logic [KW-1:0]   srt_rkey;
   logic [AW-1:0]   srt_rid;

   logic [KW-1:0]   req_key_w;
   logic [CW-1:0]   mid;
   logic [CW-1:0]   dist_m1;
   logic            key_below;
   logic            hit;

   sst_ram #(.WIDTH(KW), .DEPTH(CAPACITY)) u_id_ram (
      .clock (clock),
      .we    (id_we),
      .waddr (id_waddr),
      .wdata (id_wdata),
      .raddr (id_raddr),
      .rdata (id_rdata)
   );

   sst_ram #(.WIDTH(SW), .DEPTH(CAPACITY)) u_sorted_ram (
      .clock (clock),
      .we    (srt_we),
      .waddr (srt_waddr),
      .wdata (srt_wdata),
      .raddr (srt_raddr),
      .rdata (srt_rdata)
   );

   assign srt_rkey  = srt_rdata[SW-1:AW];
   assign srt_rid   = srt_rdata[AW-1:0];
   assign req_key_w = KW'($unsigned(req.key));
   assign mid       = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign dist_m1   = distinct_ff - CW'(1);
   // Signed order: flip the sign bits and compare as unsigned.
   assign key_below = {~srt_rkey[KW-1], srt_rkey[KW-2:0]} <
                      {~key_ff[KW-1], key_ff[KW-2:0]};
   assign hit       = (lo_ff < distinct_ff) && (srt_rkey == key_ff);

   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      key_in        = key_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      sp_in         = sp_ff;
      nid_in        = nid_ff;
      added_in      = added_ff;
      distinct_in   = distinct_ff;
      res_status_in = res_status_ff;
      res_id_in     = res_id_ff;
      res_kout_in   = res_kout_ff;
      id_we         = 1'b0;
      id_waddr      = added_ff[AW-1:0];
      id_wdata      = req_key_w;
      id_raddr      = AW'(req.index);
      srt_we        = 1'b0;
      srt_waddr     = lo_ff[AW-1:0];
      srt_wdata     = {key_ff, nid_ff};
      srt_raddr     = lo_ff[AW-1:0];

      unique case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               mode_in       = req.mode;
               key_in        = req_key_w;
               lo_in         = '0;
               hi_in         = distinct_ff;
               res_status_in = STATUS_OK;
               res_id_in     = '0;
               res_kout_in   = '0;
               unique case (req.mode)
                  MODE_ADD: begin
                     if (added_ff == CW'(CAPACITY)) begin
                        res_status_in = STATUS_FULL;
                        state_in      = S_DONE;
                     end else begin
                        id_we    = 1'b1;
                        nid_in   = added_ff[AW-1:0];
                        added_in = added_ff + CW'(1);
                        state_in = S_SEARCH;
                     end
                  end
                  MODE_LOOKUP: begin
                     state_in = S_SEARCH;
                  end
                  MODE_READ_ID: begin
                     if (CMPW'(req.index) < CMPW'(added_ff)) begin
                        res_id_in = req.index;
                        state_in  = S_READ;
                     end else begin
                        res_status_in = STATUS_RANGE;
                        state_in      = S_DONE;
                     end
                  end
                  MODE_READ_RANK: begin
                     srt_raddr = AW'(req.index);
                     if (CMPW'(req.index) < CMPW'(distinct_ff)) begin
                        state_in = S_READ;
                     end else begin
                        res_status_in = STATUS_RANGE;
                        state_in      = S_DONE;
                     end
                  end
               endcase
            end
         end
         S_SEARCH: begin
            if (lo_ff < hi_ff) begin
               srt_raddr = mid[AW-1:0];
               state_in  = S_COMPARE;
            end else begin
               srt_raddr = lo_ff[AW-1:0];
               state_in  = S_PROBE;
            end
         end
         S_COMPARE: begin
            if (key_below) begin
               lo_in = mid + CW'(1);
            end else begin
               hi_in = mid;
            end
            state_in = S_SEARCH;
         end
         S_PROBE: begin
            if (mode_ff == MODE_LOOKUP) begin
               if (hit) begin
                  res_id_in   = ID_W'(srt_rid);
                  res_kout_in = key_ff;
               end else begin
                  res_status_in = STATUS_NOT_FOUND;
               end
               state_in = S_DONE;
            end else begin
               res_id_in   = ID_W'(nid_ff);
               res_kout_in = key_ff;
               if (hit) begin
                  // Key already present: only its id moves to the new one.
                  srt_we   = 1'b1;
                  state_in = S_DONE;
               end else if (lo_ff == distinct_ff) begin
                  srt_we      = 1'b1;
                  distinct_in = distinct_ff + CW'(1);
                  state_in    = S_DONE;
               end else begin
                  sp_in     = dist_m1[AW-1:0];
                  srt_raddr = dist_m1[AW-1:0];
                  state_in  = S_SHIFT;
               end
            end
         end
         S_SHIFT: begin
            // Entry read last cycle moves up by one place.
            srt_we    = 1'b1;
            srt_waddr = sp_ff + AW'(1);
            srt_wdata = srt_rdata;
            if (sp_ff == lo_ff[AW-1:0]) begin
               state_in = S_INSERT;
            end else begin
               sp_in     = sp_ff - AW'(1);
               srt_raddr = sp_ff - AW'(1);
            end
         end
         S_INSERT: begin
            srt_we      = 1'b1;
            distinct_in = distinct_ff + CW'(1);
            state_in    = S_DONE;
         end
         S_READ: begin
            if (mode_ff == MODE_READ_ID) begin
               res_kout_in = id_rdata;
            end else begin
               res_id_in   = ID_W'(srt_rid);
               res_kout_in = srt_rkey;
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         added_ff    <= '0;
         distinct_ff <= '0;
      end else begin
         state_ff    <= state_in;
         added_ff    <= added_in;
         distinct_ff <= distinct_in;
      end
      mode_ff       <= mode_in;
      key_ff        <= key_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      sp_ff         <= sp_in;
      nid_ff        <= nid_in;
      res_status_ff <= res_status_in;
      res_id_ff     <= res_id_in;
      res_kout_ff   <= res_kout_in;
   end

   assign req.ready        = (state_ff == S_IDLE);
   assign res_valid        = (state_ff == S_DONE);
   assign res.status       = res_status_ff;
   assign res.id           = res_id_ff;
   assign res.key_out      = KEY_FIELD_W'(res_kout_ff);
   assign res.unique_count = COUNT_W'(distinct_ff);
   assign res.total_count  = COUNT_W'(added_ff);

endmodule
